/* rtl/pbo_pkg.sv */
// Shared types and constants for the palette and button overlay compositor.
// Holds the configuration record, per-button hit flags, fill colors and label glyphs.
// No dependencies.
package pbo_pkg;

  localparam int NUM_BUTTONS = 4;
  localparam int CALC_W      = 20;

  localparam logic [15:0] WHITE = 16'hFFFF;

  typedef enum logic [2:0] {
    REG_PALETTE  = 3'd0,
    REG_BUTTON_X = 3'd1,
    REG_BUTTON_Y = 3'd2,
    REG_BUTTON_W = 3'd3,
    REG_BUTTON_H = 3'd4
  } pbo_reg_e;

  typedef struct packed {
    logic [63:0] palette;
    logic [63:0] button_x;
    logic [63:0] button_y;
    logic [63:0] button_w;
    logic [63:0] button_h;
  } pbo_cfg_t;

  typedef struct packed {
    logic white;
    logic fill;
  } pbo_hit_t;

  localparam logic [15:0] FILL_COLORS [NUM_BUTTONS] = '{
    16'h02BF, 16'h07E0, 16'h07FF, 16'hFD20
  };

  // Glyphs: A, B, E, L, S, T
  localparam logic [4:0] GLYPH_ROWS [6][7] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}
  };

  // Labels: "B", "A", "SEL", "ST"
  localparam int LABEL_GLYPHS [NUM_BUTTONS][3] = '{
    '{1, 0, 0}, '{0, 0, 0}, '{4, 2, 3}, '{4, 5, 0}
  };
  localparam int LABEL_LEN [NUM_BUTTONS] = '{1, 1, 3, 2};

endpackage

/* rtl/pbo_cfg.sv */
// Configuration register file of the overlay compositor.
// Takes register writes by index and presents all registers as one record.
// Depends on pbo_pkg.
module pbo_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [63:0]     cfg_data_i,
  output pbo_pkg::pbo_cfg_t cfg_o
);
  import pbo_pkg::*;

  pbo_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (pbo_reg_e'(cfg_index_i))
        REG_PALETTE:  cfg_q.palette  <= cfg_data_i;
        REG_BUTTON_X: cfg_q.button_x <= cfg_data_i;
        REG_BUTTON_Y: cfg_q.button_y <= cfg_data_i;
        REG_BUTTON_W: cfg_q.button_w <= cfg_data_i;
        REG_BUTTON_H: cfg_q.button_h <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

/* rtl/pbo_button.sv */
// Hit logic of one on-screen button: border, label and checkerboard fill.
// Clips to the frame and suppresses buttons lying fully above or below it.
// Depends on pbo_pkg.
module pbo_button #(
  parameter int BUTTON_IDX   = 0,
  parameter int FRAME_WIDTH  = 160,
  parameter int FRAME_HEIGHT = 144
) (
  input  logic [7:0]  px_i,
  input  logic [7:0]  py_i,
  input  logic [15:0] bx_i,
  input  logic [15:0] by_i,
  input  logic [15:0] bw_i,
  input  logic [15:0] bh_i,
  output pbo_pkg::pbo_hit_t hit_o
);
  import pbo_pkg::*;

  localparam int Len   = LABEL_LEN[BUTTON_IDX];
  localparam int TextW = (Len * 6 - 1) * 2;
  localparam logic signed [CALC_W-1:0] FrameW = CALC_W'(FRAME_WIDTH);
  localparam logic signed [CALC_W-1:0] FrameH = CALC_W'(FRAME_HEIGHT);

  function automatic logic signed [CALC_W-1:0] half_tz(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] t;
    t = v + {{(CALC_W-1){1'b0}}, v[CALC_W-1]};
    return t >>> 1;
  endfunction

  logic signed [CALC_W-1:0] px, py, bx, by, bw, bh;
  logic signed [CALC_W-1:0] yend, xend, xs, xe, cur, sy, dy;
  logic in_rows, in_cols, visible, border, label;
  logic [4:0] row;

  assign px = {{(CALC_W-8){1'b0}}, px_i};
  assign py = {{(CALC_W-8){1'b0}}, py_i};
  assign bx = {{(CALC_W-16){bx_i[15]}}, bx_i};
  assign by = {{(CALC_W-16){by_i[15]}}, by_i};
  assign bw = {{(CALC_W-16){1'b0}}, bw_i};
  assign bh = {{(CALC_W-16){1'b0}}, bh_i};

  assign yend = by + bh;
  assign xend = bx + bw;
  assign xs   = (bx < 0) ? '0 : bx;
  assign xe   = (xend > FrameW) ? FrameW : xend;

  assign in_rows = (py >= by) && (py < yend);
  assign in_cols = (px >= xs) && (px < xe);
  assign visible = !((yend <= 0) || (by >= FrameH));

  assign border =
    (in_cols && ((py == by) || (py == by + 1) || (py == yend - 1) || (py == yend - 2))) ||
    (in_rows && ((px == bx) || (px == bx + 1) || (px == xend - 1) || (px == xend - 2)));

  assign cur = bx + half_tz(bw - CALC_W'(TextW));
  assign sy  = by + half_tz(bh - CALC_W'(14));
  assign dy  = py - sy;

  always_comb begin
    logic signed [CALC_W-1:0] dx;
    logic [4:0] shifted;
    logic       dy_ok;
    label = 1'b0;
    row   = '0;
    dy_ok = (dy >= 0) && (dy < CALC_W'(14));
    for (int i = 0; i < 3; i++) begin
      if (i < Len) begin
        row     = GLYPH_ROWS[LABEL_GLYPHS[BUTTON_IDX][i]][dy[3:1]];
        dx      = px - cur - CALC_W'(12 * i);
        shifted = row << dx[3:1];
        if (dy_ok && (dx >= 0) && (dx < CALC_W'(10)) && shifted[4]) begin
          label = 1'b1;
        end
      end
    end
  end

  assign hit_o.white = visible && (border || label);
  assign hit_o.fill  = visible && in_rows && in_cols && !py[0] && (px[0] == xs[0]);

endmodule

/* rtl/palette_button_overlay_compositor.sv */
// Palette lookup and four-button overlay compositor, top level.
// Instantiates pbo_cfg and four pbo_button lanes; depends on pbo_pkg.
//
// One pixel enters per cycle and its byte-swapped RGB565 color leaves through an input
// register and a result register; the path between them holds the palette lookup and the
// compare logic of all four buttons side by side. Throughput is one pixel per clock for
// as long as the output side takes transfers. Configuration writes complete in the cycle
// they are presented.
module palette_button_overlay_compositor #(
  parameter int FRAME_WIDTH  = 160,
  parameter int FRAME_HEIGHT = 144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_x, pixel_y, color_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // pixel_color
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import pbo_pkg::*;

  pbo_cfg_t  cfg;
  pbo_hit_t  hits [NUM_BUTTONS];

  logic       in_valid_q;
  logic [7:0] px_q, py_q;
  logic [1:0] ci_q;
  logic       out_valid_q;
  logic [15:0] color_q;
  logic       out_ready, in_ready, in_frame;
  logic [15:0] color_d;

  pbo_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  for (genvar k = 0; k < NUM_BUTTONS; k++) begin : g_button
    pbo_button #(
      .BUTTON_IDX   (k),
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_button (
      .px_i  (px_q),
      .py_i  (py_q),
      .bx_i  (cfg.button_x[16*k +: 16]),
      .by_i  (cfg.button_y[16*k +: 16]),
      .bw_i  (cfg.button_w[16*k +: 16]),
      .bh_i  (cfg.button_h[16*k +: 16]),
      .hit_o (hits[k])
    );
  end

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign in_ready      = !in_valid_q || out_ready;
  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = color_q;

  assign in_frame = ({{(CALC_W-8){1'b0}}, px_q} < CALC_W'(FRAME_WIDTH)) &&
                    ({{(CALC_W-8){1'b0}}, py_q} < CALC_W'(FRAME_HEIGHT));

  always_comb begin
    logic [15:0] c;
    c = cfg.palette[{ci_q, 4'b0000} +: 16];
    if (in_frame) begin
      for (int k = 0; k < NUM_BUTTONS; k++) begin
        if (hits[k].white) begin
          c = WHITE;
        end else if (hits[k].fill) begin
          c = FILL_COLORS[k];
        end
      end
    end
    color_d = {c[7:0], c[15:8]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid) begin
      px_q <= s_axis_tdata[7:0];
      py_q <= s_axis_tdata[15:8];
      ci_q <= s_axis_tdata[17:16];
    end
    if (out_ready && in_valid_q) begin
      color_q <= color_d;
    end
  end

endmodule
